// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSAMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssamd assertion failed");

// next-cycle implication, checked outside reset
`define SSAMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssamd assertion failed");

`endif

// File: hw/rtl/ssamd_pkg.sv
// shared constants, codes and types of the signed shift-add / shift-subtract unit
// no dependencies
`default_nettype none

package ssamd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } ssamd_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_FIX
  } ssamd_state_t;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } ssamd_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic iterate;
  } ssamd_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/signed_shift_add_mul_div_unit_core.sv
// top level of the signed add / subtract / multiply / divide unit
// depends on ssamd_pkg, ssamd_seq, ssamd_dp and assert_macros.svh
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_ready   in_func, in_operand_a, in_operand_b
// out_      output     out_valid / out_ready out_result, out_div_by_zero
//
// one transaction at a time: accept in idle, form magnitudes and signs in the prep state, run the
// radix-2 loop over all DATA_WIDTH bits in the run state, then pass through the sign-fix stage
// add, subtract and divides by or of zero skip the loop and go from the prep state to sign fix
// the result is parked in an output register, so the next transaction is taken while it waits;
// the sign-fix stage holds only if that register is still full; rst_n is synchronous, active low

`include "assert_macros.svh"

module signed_shift_add_mul_div_unit_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [1:0]                        in_func,
  input  wire [ssamd_pkg::DATA_WIDTH-1:0]  in_operand_a,
  input  wire [ssamd_pkg::DATA_WIDTH-1:0]  in_operand_b,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [ssamd_pkg::DATA_WIDTH-1:0] out_result,
  output logic                             out_div_by_zero
);
  import ssamd_pkg::*;

  ssamd_ctrl_t           ctrl;
  ssamd_stat_t           stat;
  logic [DATA_WIDTH-1:0] dp_res;
  logic                  dp_dz;
  logic                  out_free;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_result_r;
  logic                  out_dz_r;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  ssamd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ssamd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_func      (in_func),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .stat         (stat),
    .res          (dp_res),
    .dz           (dp_dz)
  );

  // output valid: set on finish, cleared when the transaction leaves
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded only on finish
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_result_r <= dp_res;
      out_dz_r     <= dp_dz;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_div_by_zero = out_dz_r;

  `SSAMD_ASSERT_NOW(a_finish_free, ctrl.finish, out_free)
  `SSAMD_ASSERT_NEXT(a_finish_valid, ctrl.finish, out_valid_r)
  `SSAMD_ASSERT_NEXT(a_busy_after_load, ctrl.load, !in_ready)

endmodule

`default_nettype wire

// File: hw/rtl/ssamd_seq.sv
// sequencer: state machine and bit counter of the iterative unit
// depends on ssamd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ssamd_seq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 out_free,
  input  ssamd_pkg::ssamd_stat_t stat,
  output ssamd_pkg::ssamd_ctrl_t ctrl
);
  import ssamd_pkg::*;

  ssamd_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ctrl        = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        ctrl.prep = 1'b1;
        if (stat.iterate) begin
          cnt_nxt   = CNT_W'(DATA_WIDTH - 1);
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_FIX;
        end
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `SSAMD_ASSERT_NEXT(a_run_ends, (state_r == ST_RUN) && (cnt_r == '0), state_r == ST_FIX)
  `SSAMD_ASSERT_NOW(a_prep_after_load, ctrl.prep, $past(ctrl.load))

endmodule

`default_nettype wire

// File: hw/rtl/ssamd_dp.sv
// datapath: operand shift registers, accumulator / partial remainder, sign fix
// depends on ssamd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ssamd_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  ssamd_pkg::ssamd_ctrl_t           ctrl,
  input  wire [1:0]                        in_func,
  input  wire [ssamd_pkg::DATA_WIDTH-1:0]  in_operand_a,
  input  wire [ssamd_pkg::DATA_WIDTH-1:0]  in_operand_b,
  output ssamd_pkg::ssamd_stat_t           stat,
  output logic [ssamd_pkg::DATA_WIDTH-1:0] res,
  output logic                             dz
);
  import ssamd_pkg::*;

  localparam int W = DATA_WIDTH;

  ssamd_func_t   func_r;
  logic [W-1:0]  opa_r, opa_nxt;   // multiplicand, or dividend then quotient
  logic [W-1:0]  opb_r, opb_nxt;   // multiplier bits, or divisor
  logic [W-1:0]  acc_r, acc_nxt;   // sum, difference, product or partial remainder
  logic          neg_r, neg_nxt;
  logic          quo_r, quo_nxt;   // final value sits in opa
  logic          dz_r, dz_nxt;

  logic          a_neg, b_neg, a_zero, b_zero;
  logic [W-1:0]  mag_a, mag_b, fin;
  logic [W:0]    rem_sh, rem_sub;
  logic          ge;

  assign a_neg  = opa_r[W-1];
  assign b_neg  = opb_r[W-1];
  assign a_zero = (opa_r == '0);
  assign b_zero = (opb_r == '0);
  assign mag_a  = a_neg ? (W'(0) - opa_r) : opa_r;
  assign mag_b  = b_neg ? (W'(0) - opb_r) : opb_r;

  assign stat.iterate = (func_r == FUNC_MUL) || ((func_r == FUNC_DIV) && !a_zero && !b_zero);

  // restoring step, one bit wider so the doubled remainder cannot overflow
  assign rem_sh  = {acc_r, opa_r[W-1]};
  assign ge      = (rem_sh >= {1'b0, opb_r});
  assign rem_sub = rem_sh - {1'b0, opb_r};

  always_comb begin
    opa_nxt = opa_r;
    opb_nxt = opb_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    quo_nxt = quo_r;
    dz_nxt  = dz_r;
    priority if (ctrl.load) begin
      opa_nxt = in_operand_a;
      opb_nxt = in_operand_b;
      dz_nxt  = 1'b0;
    end else if (ctrl.prep) begin
      neg_nxt = 1'b0;
      quo_nxt = 1'b0;
      acc_nxt = '0;
      unique case (func_r)
        FUNC_ADD: acc_nxt = opa_r + opb_r;
        FUNC_SUB: acc_nxt = opa_r - opb_r;
        FUNC_MUL: begin
          opa_nxt = mag_a;
          opb_nxt = mag_b;
          neg_nxt = a_neg ^ b_neg;
        end
        FUNC_DIV: begin
          if (!a_zero && b_zero) begin
            dz_nxt = 1'b1;
          end else if (!a_zero) begin
            opa_nxt = mag_a;
            opb_nxt = mag_b;
            neg_nxt = a_neg ^ b_neg;
            quo_nxt = 1'b1;
          end
        end
        default: acc_nxt = '0;
      endcase
    end else if (ctrl.step) begin
      if (func_r == FUNC_MUL) begin
        acc_nxt = acc_r + (opb_r[0] ? opa_r : '0);
        opa_nxt = {opa_r[W-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[W-1:1]};
      end else begin
        acc_nxt = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        opa_nxt = {opa_r[W-2:0], ge};
      end
    end else begin
      // idle or waiting on the output: every register holds
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= 1'b0;
    end else begin
      dz_r <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      func_r <= ssamd_func_t'(in_func);
    end
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  assign fin = quo_r ? opa_r : acc_r;
  assign res = neg_r ? (W'(0) - fin) : fin;
  assign dz  = dz_r;

  `SSAMD_ASSERT_NOW(a_dz_only_div, dz_r, func_r == FUNC_DIV)
  `SSAMD_ASSERT_NOW(a_dz_zero_res, dz_r && !ctrl.load, res == '0)

endmodule

`default_nettype wire

// File: dv/tb_signed_shift_add_mul_div_unit_core.sv
// self-checking bench for signed_shift_add_mul_div_unit_core: add, subtract, multiply, divide
// depends on ssamd_pkg for DATA_WIDTH and the function codes; the block's rtl is the only other need
// a queue-fed driver and a clocked monitor check every result against an in-bench predictor

module tb_signed_shift_add_mul_div_unit_core;
  import ssamd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};
  localparam int N_RANDOM = 500;
  localparam int HOLD_CYCLES = 400;          // long receiver hold-off
  localparam int HOLD_AFTER = 150;           // results seen before the hold-off starts
  localparam int DRAIN_CYCLES = 2 * (W + 2) + 10;
  localparam int CYCLE_LIMIT = 250000;

  // one operation offered on the input channel
  typedef struct {
    ssamd_func_t      func;
    logic [W-1:0]     a;
    logic [W-1:0]     b;
  } alu_op_t;

  // what the block must return for one operation
  typedef struct {
    logic [W-1:0] result;
    logic         div_by_zero;
  } alu_answer_t;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [1:0]   in_func;
  logic [W-1:0] in_operand_a;
  logic [W-1:0] in_operand_b;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] out_result;
  logic         out_div_by_zero;

  alu_op_t     ops_pending[$];
  alu_answer_t answers_due[$];

  int n_ops_total;
  int n_ops_taken;
  int n_answers;
  int n_errors;
  int n_cycles;
  bit in_taken;     // set at the rising edge that accepts the transaction on the input

  signed_shift_add_mul_div_unit_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_operand_a    (in_operand_a),
    .in_operand_b    (in_operand_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result      (out_result),
    .out_div_by_zero (out_div_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: signed four-function result on unsigned magnitudes
  // ---------------------------------------------------------------------------
  function automatic alu_answer_t calc_answer(ssamd_func_t func, logic [W-1:0] a,
                                              logic [W-1:0] b);
    alu_answer_t  ans;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] mag_res;
    logic         neg;
    // the most negative value negates onto itself, which read unsigned is its magnitude
    mag_a = a[W-1] ? (~a + 1'b1) : a;
    mag_b = b[W-1] ? (~b + 1'b1) : b;
    neg = a[W-1] ^ b[W-1];
    ans.div_by_zero = 1'b0;
    ans.result = '0;
    case (func)
      FUNC_ADD: ans.result = a + b;
      FUNC_SUB: ans.result = a - b;
      FUNC_MUL: begin
        // low W bits of the magnitude product, then the sign
        mag_res = mag_a * mag_b;
        ans.result = neg ? (~mag_res + 1'b1) : mag_res;
      end
      default: begin
        // zero dividend wins over zero divisor
        if (a == '0) begin
          ans.result = '0;
        end else if (b == '0) begin
          ans.div_by_zero = 1'b1;
        end else begin
          mag_res = mag_a / mag_b;
          ans.result = neg ? (~mag_res + 1'b1) : mag_res;
        end
      end
    endcase
    return ans;
  endfunction

  // operand mix: extremes, zero, small values and full-width random
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = MOST_NEG;
      2: v = MOST_POS;
      3: v = MINUS_ONE;
      4: v = {{(W-1){1'b0}}, 1'b1};
      5: v = W'($signed($urandom_range(0, 64)) - 32);
      6: v = W'($signed({$urandom_range(0, 65535)}) - 32768);
      7: v = MOST_NEG + W'($urandom_range(0, 3));
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_op(ssamd_func_t func, logic [W-1:0] a, logic [W-1:0] b);
    alu_op_t op;
    op.func = func;
    op.a = a;
    op.b = b;
    ops_pending.push_back(op);
  endtask

  // ---------------------------------------------------------------------------
  // input tap and result checker, both on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alu_answer_t exp_ans;
    if (rst_n) begin
      // expectation is formed from the payload held at the accepting edge
      if (in_valid && in_ready) begin
        answers_due.push_back(calc_answer(ssamd_func_t'(in_func), in_operand_a, in_operand_b));
        n_ops_taken++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        n_answers++;
        if (answers_due.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing outstanding: result %h div_by_zero %b",
                   $time, out_result, out_div_by_zero);
        end else begin
          exp_ans = answers_due.pop_front();
          if (out_result !== exp_ans.result) begin
            n_errors++;
            $display("%0t: result mismatch: expected %h actual %h",
                     $time, exp_ans.result, out_result);
          end
          if (out_div_by_zero !== exp_ans.div_by_zero) begin
            n_errors++;
            $display("%0t: div_by_zero mismatch: expected %b actual %b",
                     $time, exp_ans.div_by_zero, out_div_by_zero);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of transactions separated by random gaps, on the falling edge
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    alu_op_t op;
    logic    nxt_valid;
    nxt_valid = in_valid;
    if (in_taken) begin
      in_taken = 1'b0;
      nxt_valid = 1'b0;
    end
    // a transaction still waiting for ready keeps valid and payload untouched
    if (rst_n && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (ops_pending.size() > 0) begin
        op = ops_pending.pop_front();
        in_func <= op.func;
        in_operand_a <= op.a;
        in_operand_b <= op.b;
        nxt_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          // some bursts run back to back
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // ---------------------------------------------------------------------------
  // receiver: randomly chosen stall patterns, plus one long hold-off
  // ---------------------------------------------------------------------------
  int  rx_phase = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    logic nxt_ready;
    rx_phase++;
    if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 4);
    if (!hold_done && n_answers >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    case (rx_mode)
      0: nxt_ready = 1'b1;
      1: nxt_ready = ($urandom_range(0, 9) < 7);
      2: nxt_ready = (rx_phase % 3 == 0);
      3: nxt_ready = ($urandom_range(0, 9) < 3);
      default: nxt_ready = (rx_phase % 16 < 8);
    endcase
    // block fills up behind the held output and must stall its input
    if (hold_left > 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  // run time guard
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of test
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    out_ready = 1'b0;
    n_ops_taken = 0;
    n_answers = 0;
    n_errors = 0;
    n_cycles = 0;
    in_taken = 1'b0;

    // directed: wrap of add and subtract
    queue_op(FUNC_ADD, MOST_POS, 1);
    queue_op(FUNC_ADD, MOST_NEG, MOST_NEG);
    queue_op(FUNC_ADD, MINUS_ONE, MINUS_ONE);
    queue_op(FUNC_SUB, MOST_NEG, 1);
    queue_op(FUNC_SUB, '0, MOST_NEG);
    queue_op(FUNC_SUB, MOST_POS, MINUS_ONE);
    // product overflow and signs
    queue_op(FUNC_MUL, MOST_POS, MOST_POS);
    queue_op(FUNC_MUL, MOST_NEG, MINUS_ONE);
    queue_op(FUNC_MUL, MOST_NEG, MOST_NEG);
    queue_op(FUNC_MUL, W'(-7), 6);
    queue_op(FUNC_MUL, W'(-7), W'(-6));
    queue_op(FUNC_MUL, '0, MOST_NEG);
    queue_op(FUNC_MUL, 32'h0001_0001, 32'h0001_0001);
    // zero dividend beats zero divisor
    queue_op(FUNC_DIV, '0, '0);
    queue_op(FUNC_DIV, '0, 5);
    queue_op(FUNC_DIV, 7, '0);
    queue_op(FUNC_DIV, MOST_NEG, '0);
    // most negative over minus one wraps back onto itself
    queue_op(FUNC_DIV, MOST_NEG, MINUS_ONE);
    queue_op(FUNC_DIV, W'(-7), 2);
    queue_op(FUNC_DIV, 7, W'(-2));
    queue_op(FUNC_DIV, W'(-7), W'(-2));
    queue_op(FUNC_DIV, MOST_POS, 1);
    queue_op(FUNC_DIV, 1, MOST_POS);
    queue_op(FUNC_DIV, MOST_NEG, MOST_NEG);
    queue_op(FUNC_DIV, MOST_POS, MOST_NEG);

    for (int i = 0; i < N_RANDOM; i++) begin
      queue_op(ssamd_func_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
    end
    n_ops_total = ops_pending.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_ops_taken < n_ops_total || answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
